@@ design/lsws_pkg.sv @@
package lsws_pkg;

  // Default stack depth
  localparam int unsigned DefDepth = 8;
  localparam int unsigned WordW    = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } fsm_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [WordW-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0]  data_out;
    status_e                  status;
    logic                     found;
    logic                     is_full;
    logic                     is_empty;
    logic                     last;
  } out_t;

  // Per-cell shift control
  typedef struct packed {
    logic shift_dn;  // take the word from the cell above (push)
    logic shift_up;  // take the word from the cell below (pop, rotate)
  } cell_ctl_t;

endpackage

@@ design/lsws_cell.sv @@
module lsws_cell (
  input  logic                          clk_i,
  input  lsws_pkg::cell_ctl_t           ctl_i,
  input  logic [lsws_pkg::WordW-1:0]    above_i,
  input  logic [lsws_pkg::WordW-1:0]    below_i,
  input  logic                          valid_i,
  input  logic [lsws_pkg::WordW-1:0]    key_i,
  output logic [lsws_pkg::WordW-1:0]    data_o,
  output logic                          match_o
);

  logic [lsws_pkg::WordW-1:0] data_q;

  // Stored word: shifts towards the bottom on push, towards the top on pop
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_dn) begin
      data_q <= above_i;
    end else if (ctl_i.shift_up) begin
      data_q <= below_i;
    end
  end

  // Local compare for search, only for occupied cells
  assign match_o = valid_i && (data_q == key_i);
  assign data_o  = data_q;

endmodule

@@ design/lifo_stack_with_search_unit.sv @@
// Push, pop, search and a dump of an empty stack strobe their result in the
// cycle after acceptance; busy_o stays low, so these take one beat per cycle.
// Dump of N entries: busy_o is high while the sequencer is in its dump state,
// which gives N result beats; each beat is registered, so the last one comes
// in the cycle in which busy_o has just fallen.
// Reset clears the fill count (stack empty); stored words stay undefined.
// The receiver cannot stall: each result is on res_o for exactly one cycle.
module lifo_stack_with_search_unit #(
  parameter int unsigned DEPTH = lsws_pkg::DefDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  lsws_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           done_o,
  output lsws_pkg::out_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  dump_cnt_q, dump_cnt_d;
  lsws_pkg::fsm_e   fsm_q, fsm_d;
  logic             done_q, done_d;
  lsws_pkg::out_t   res_q, res_d;

  logic                        accept;
  logic                        is_full, is_empty, dumping;
  lsws_pkg::cell_ctl_t         ctl;
  logic [lsws_pkg::WordW-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]            match;

  assign dumping  = (fsm_q == lsws_pkg::FSM_DUMP);
  assign busy_o   = dumping;
  assign accept   = start_i && !busy_o;
  assign is_full  = (cnt_q == CntW'(DEPTH));
  assign is_empty = (cnt_q == '0);

  // Shift control shared by every cell
  always_comb begin
    ctl.shift_dn = accept && (in_i.operation == lsws_pkg::OP_PUSH) && !is_full;
    ctl.shift_up = (accept && (in_i.operation == lsws_pkg::OP_POP) && !is_empty) || dumping;
  end

  // Chain of cells, cell 0 holds the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [lsws_pkg::WordW-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = in_i.value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    // During a dump the lowest occupied cell takes the top word, so the
    // contents rotate and come back to place after one full pass
    if (i == DEPTH - 1) begin : g_bot
      assign below = cell_data[0];
    end else begin : g_nxt
      assign below = (dumping && (cnt_q == CntW'(i + 1))) ? cell_data[0] : cell_data[i+1];
    end

    lsws_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .valid_i (CntW'(i) < cnt_q),
      .key_i   (in_i.value),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  // Sequencer and result register
  always_comb begin
    cnt_d             = cnt_q;
    dump_cnt_d        = dump_cnt_q;
    fsm_d             = fsm_q;
    done_d            = 1'b0;
    res_d             = res_q;
    res_d.data_out    = '0;
    res_d.status      = lsws_pkg::ST_OK;
    res_d.found       = 1'b0;
    res_d.last        = 1'b1;

    case (fsm_q)
      lsws_pkg::FSM_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (in_i.operation)
            lsws_pkg::OP_PUSH: begin
              if (is_full) begin
                res_d.status = lsws_pkg::ST_FULL;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            lsws_pkg::OP_POP: begin
              if (is_empty) begin
                res_d.status = lsws_pkg::ST_EMPTY;
              end else begin
                cnt_d          = cnt_q - 1'b1;
                res_d.data_out = $signed(cell_data[0]);
              end
            end
            lsws_pkg::OP_SEARCH: begin
              res_d.found = |match;
            end
            lsws_pkg::OP_DUMP: begin
              if (is_empty) begin
                res_d.status = lsws_pkg::ST_EMPTY;
              end else begin
                done_d     = 1'b0;
                dump_cnt_d = cnt_q;
                fsm_d      = lsws_pkg::FSM_DUMP;
              end
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      lsws_pkg::FSM_DUMP: begin
        done_d         = 1'b1;
        res_d.data_out = $signed(cell_data[0]);
        res_d.last     = (dump_cnt_q == CntW'(1));
        dump_cnt_d     = dump_cnt_q - 1'b1;
        if (dump_cnt_q == CntW'(1)) begin
          fsm_d = lsws_pkg::FSM_IDLE;
        end
      end
      default: begin
        fsm_d = lsws_pkg::FSM_IDLE;
      end
    endcase

    res_d.is_full  = (cnt_d == CntW'(DEPTH));
    res_d.is_empty = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      dump_cnt_q <= '0;
      fsm_q      <= lsws_pkg::FSM_IDLE;
      done_q     <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      dump_cnt_q <= dump_cnt_d;
      fsm_q      <= fsm_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_dump_keeps_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dumping |=> (cnt_q == $past(cnt_q)))
    else $error("fill count changed during dump");

  a_dump_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dumping && (dump_cnt_q == CntW'(1))) |=> (!busy_o && done_o && res_o.last))
    else $error("dump did not end with a last beat");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.is_full && res_o.is_empty))
    else $error("full and empty flagged together");

endmodule
